/* rtl/ldsolve_pkg.sv */
// Shared types, widths and sequencer states of the linear Diophantine solver.
package ldsolve_pkg;

   // Field widths of one request and one result
   localparam int COEF_W     = 31;
   localparam int TARGET_W   = 32;
   localparam int DATA_WIDTH = 32;

   // Shared divider: 32-bit dividend, 31-bit divisor
   localparam int DIV_W   = 32;
   localparam int DVS_W   = 31;
   localparam int DCNT_W  = $clog2(DIV_W);

   // Shared multiplier: signed operands, products kept modulo 2^64
   localparam int OPW   = 34;
   localparam int PRODW = 64;

   typedef struct packed {
      logic [COEF_W-1:0]          coef_a;
      logic [COEF_W-1:0]          coef_b;
      logic signed [TARGET_W-1:0] target_c;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sol_x;
      logic signed [DATA_WIDTH-1:0] sol_y;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDIV,
      ST_EWAIT,
      ST_EMK,
      ST_EML,
      ST_EUPD,
      ST_GDIV,
      ST_GWAIT,
      ST_TA,
      ST_TB,
      ST_TC,
      ST_SX,
      ST_SY,
      ST_SZ,
      ST_FIN
   } state_type;

endpackage

/* rtl/ldsolve_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module ldsolve_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ldsolve_pkg::DIV_W-1:0] dividend,
   input  logic [ldsolve_pkg::DVS_W-1:0] divisor,
   output logic                          done,
   output logic [ldsolve_pkg::DIV_W-1:0] quotient,
   output logic [ldsolve_pkg::DVS_W-1:0] remainder
);
   import ldsolve_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   // Shift the next dividend bit into the partial remainder and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/ldsolve_mul.sv */
// Shared signed multiplier with registered product kept modulo 2^64.
module ldsolve_mul (
   input  logic                                clock,
   input  logic signed [ldsolve_pkg::OPW-1:0]  op_a,
   input  logic signed [ldsolve_pkg::OPW-1:0]  op_b,
   output logic        [ldsolve_pkg::PRODW-1:0] prod
);
   import ldsolve_pkg::*;

   logic signed [2*OPW-1:0] full;
   logic [PRODW-1:0]        prod_ff, prod_in;

   // Multiply and keep the low word
   always_comb begin
      full    = op_a * op_b;
      prod_in = full[PRODW-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* rtl/linear_diophantine_solver_core.sv */
// Top level of the linear Diophantine solver: sequencer around a shared divider and multiplier.
//
// Solves a*x + b*y = c for one request at a time with the extended Euclidean algorithm and
// returns one pair x, y (0,0 when there is none). A request is taken when start is high and
// busy is low; busy then stays high until the cycle in which the result is shown. The result
// is shown on rsp_data while rsp_strobe is high for exactly one cycle and cannot be held off,
// so capture it then. Each Euclid round uses the shared bit-serial divider plus three
// multiply/update steps. A request with both coefficients nonzero runs the Euclid rounds, a
// division by the gcd and then the trial and scaling steps, which it skips when c is not a
// multiple of the gcd; one zero coefficient goes straight to the division by the gcd, and
// both zero go straight to the result. busy falls in the strobe cycle, so the next request
// can be taken at the edge that ends it.
module linear_diophantine_solver_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ldsolve_pkg::req_type  req_data,
   output logic                  rsp_strobe,
   output ldsolve_pkg::rsp_type  rsp_data
);
   import ldsolve_pkg::*;

   state_type state_ff, state_in;

   // Request and working registers
   logic [COEF_W-1:0]       a_ff, b_ff;
   logic                    c_neg_ff;
   logic [DIV_W-1:0]        cabs_ff;
   logic [COEF_W-1:0]       ra_ff, rb_ff;
   logic signed [OPW-1:0]   k_ff, l_ff, m_ff, n_ff;
   logic signed [OPW-1:0]   nk_ff;
   logic [OPW-1:0]          q_ff;
   logic signed [OPW-1:0]   s_ff;
   logic [PRODW-1:0]        acc_ff;
   logic [1:0]              idx_ff, sel_ff;
   logic                    found_ff;
   logic                    zero_ff;
   logic [DATA_WIDTH-1:0]   x_ff, y_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_data_ff;

   // Shared units
   logic                    div_start, div_done;
   logic [DIV_W-1:0]        div_dividend, div_quo;
   logic [DVS_W-1:0]        div_divisor, div_rem;
   logic signed [OPW-1:0]   mul_a, mul_b;
   logic [PRODW-1:0]        prod;

   logic                    a_ge_b;
   logic [COEF_W-1:0]       g_val;
   logic signed [OPW-1:0]   u_try, v_try, u_win, v_win;
   logic                    match;
   logic [OPW-1:0]          quo_ext;

   ldsolve_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   ldsolve_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Pick a coefficient ordering: (k,l), (l,k), (m,n), (n,m)
   function automatic logic signed [OPW-1:0] pick_u(
      input logic [1:0] sel, input logic signed [OPW-1:0] k, input logic signed [OPW-1:0] l,
      input logic signed [OPW-1:0] m, input logic signed [OPW-1:0] n);
      logic signed [OPW-1:0] r;
      case (sel)
         2'd0:    r = k;
         2'd1:    r = l;
         2'd2:    r = m;
         default: r = n;
      endcase
      return r;
   endfunction

   function automatic logic signed [OPW-1:0] pick_v(
      input logic [1:0] sel, input logic signed [OPW-1:0] k, input logic signed [OPW-1:0] l,
      input logic signed [OPW-1:0] m, input logic signed [OPW-1:0] n);
      logic signed [OPW-1:0] r;
      case (sel)
         2'd0:    r = l;
         2'd1:    r = k;
         2'd2:    r = n;
         default: r = m;
      endcase
      return r;
   endfunction

   // Datapath helpers
   always_comb begin
      a_ge_b  = (ra_ff >= rb_ff);
      g_val   = zero_ff ? (a_ff | b_ff) : (ra_ff | rb_ff);
      u_try   = pick_u(idx_ff, k_ff, l_ff, m_ff, n_ff);
      v_try   = pick_v(idx_ff, k_ff, l_ff, m_ff, n_ff);
      u_win   = pick_u(sel_ff, k_ff, l_ff, m_ff, n_ff);
      v_win   = pick_v(sel_ff, k_ff, l_ff, m_ff, n_ff);
      match   = ((acc_ff + prod) == PRODW'(g_val));
      quo_ext = {{(OPW-DIV_W){1'b0}}, div_quo};
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.coef_a == '0 && req_data.coef_b == '0) begin
                  state_in = ST_FIN;
               end else if (req_data.coef_a == '0 || req_data.coef_b == '0) begin
                  state_in = ST_GDIV;
               end else begin
                  state_in = ST_EDIV;
               end
            end
         end
         ST_EDIV:  state_in = ST_EWAIT;
         ST_EWAIT: if (div_done) state_in = ST_EMK;
         ST_EMK:   state_in = ST_EML;
         ST_EML:   state_in = ST_EUPD;
         ST_EUPD: begin
            state_in = (ra_ff == '0 || rb_ff == '0) ? ST_GDIV : ST_EDIV;
         end
         ST_GDIV:  state_in = ST_GWAIT;
         ST_GWAIT: begin
            if (div_done) begin
               state_in = (div_rem != '0 || zero_ff) ? ST_FIN : ST_TA;
            end
         end
         ST_TA:    state_in = ST_TB;
         ST_TB:    state_in = ST_TC;
         ST_TC: begin
            if (idx_ff != 2'd3) begin
               state_in = ST_TA;
            end else begin
               state_in = (found_ff || match) ? ST_SX : ST_FIN;
            end
         end
         ST_SX:    state_in = ST_SY;
         ST_SY:    state_in = ST_SZ;
         ST_SZ:    state_in = ST_FIN;
         ST_FIN:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Unit controls and operand selection
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      div_start    = 1'b0;
      div_dividend = cabs_ff;
      div_divisor  = g_val;
      mul_a        = k_ff;
      mul_b        = $signed(q_ff);
      unique case (state_ff)
         ST_EDIV: begin
            div_start    = 1'b1;
            div_dividend = {1'b0, (a_ge_b ? ra_ff : rb_ff)};
            div_divisor  = a_ge_b ? rb_ff : ra_ff;
         end
         ST_GDIV: div_start = 1'b1;
         ST_EMK: begin
            mul_a = k_ff;
            mul_b = $signed(q_ff);
         end
         ST_EML: begin
            mul_a = l_ff;
            mul_b = $signed(q_ff);
         end
         ST_TA: begin
            mul_a = $signed(OPW'(a_ff));
            mul_b = u_try;
         end
         ST_TB: begin
            mul_a = $signed(OPW'(b_ff));
            mul_b = v_try;
         end
         ST_SX: begin
            mul_a = u_win;
            mul_b = s_ff;
         end
         ST_SY: begin
            mul_a = v_win;
            mul_b = s_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_FIN);
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            // Capture the request and seed the coefficient pairs
            a_ff     <= req_data.coef_a;
            b_ff     <= req_data.coef_b;
            c_neg_ff <= req_data.target_c[TARGET_W-1];
            cabs_ff  <= req_data.target_c[TARGET_W-1] ? (~req_data.target_c + 1'b1)
                                                      : req_data.target_c;
            ra_ff    <= req_data.coef_a;
            rb_ff    <= req_data.coef_b;
            k_ff     <= '0;
            l_ff     <= OPW'(1);
            m_ff     <= OPW'(1);
            n_ff     <= '0;
            x_ff     <= '0;
            y_ff     <= '0;
            zero_ff  <= (req_data.coef_a == '0 || req_data.coef_b == '0);
         end
         ST_EWAIT: begin
            // Replace the larger value by the remainder
            if (div_done) begin
               q_ff <= quo_ext;
               if (a_ge_b) ra_ff <= div_rem;
               else        rb_ff <= div_rem;
            end
         end
         ST_EML: nk_ff <= m_ff - $signed(prod[OPW-1:0]);
         ST_EUPD: begin
            // Advance the coefficient pairs
            m_ff <= k_ff;
            n_ff <= l_ff;
            k_ff <= nk_ff;
            l_ff <= n_ff - $signed(prod[OPW-1:0]);
         end
         ST_GWAIT: begin
            if (div_done) begin
               idx_ff   <= '0;
               found_ff <= 1'b0;
               s_ff     <= c_neg_ff ? (~quo_ext + 1'b1) : quo_ext;
               // Single nonzero coefficient: the quotient is the answer
               if (zero_ff && div_rem == '0) begin
                  if (a_ff == '0) y_ff <= c_neg_ff ? DATA_WIDTH'(~quo_ext + 1'b1)
                                                   : DATA_WIDTH'(quo_ext);
                  else            x_ff <= c_neg_ff ? DATA_WIDTH'(~quo_ext + 1'b1)
                                                   : DATA_WIDTH'(quo_ext);
               end
            end
         end
         ST_TB: acc_ff <= prod;
         ST_TC: begin
            // Keep the last ordering that gives the gcd
            if (match) begin
               found_ff <= 1'b1;
               sel_ff   <= idx_ff;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         ST_SY: x_ff <= prod[DATA_WIDTH-1:0];
         ST_SZ: y_ff <= prod[DATA_WIDTH-1:0];
         ST_FIN: begin
            rsp_data_ff.sol_x <= x_ff;
            rsp_data_ff.sol_y <= y_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
